/* rtl/cvfd_pkg.sv */
// Package for the chunked video frame deframer: header constants, result type, queue depth.
// No dependencies; used by the front end, the queue and the top level.
`timescale 1ns / 1ps

package cvfd_pkg;

   localparam int unsigned HdrLen      = 16;            // header bytes per chunk
   localparam logic [15:0] SkipKind    = 16'd258;       // chunk type whose payload is dropped silently
   localparam logic [7:0]  EndFlagMask = 8'h80;         // flag bit: chunk closes frame
   localparam logic [15:0] HdrOverhead = 16'd12;        // size minus this is payload
   localparam int unsigned QueueDepthDefault = 4;

   // header byte positions of interest
   localparam logic [3:0] PosKindLo  = 4'd1;
   localparam logic [3:0] PosLenHi   = 4'd2;
   localparam logic [3:0] PosLenLo   = 4'd3;
   localparam logic [3:0] PosFlagsLo = 4'd5;
   localparam logic [3:0] PosTimeHi  = 4'd8;
   localparam logic [3:0] PosTimeLo  = 4'd11;
   localparam logic [3:0] PosLast    = 4'd15;

   typedef struct packed {
      logic        bad_header;
      logic        frame_end;
      logic        frame_start;
      logic [31:0] frame_time;
      logic [7:0]  payload_byte;
   } result_type;

endpackage

/* rtl/cvfd_front.sv */
// Front end of the deframer: header parse, chunk and frame tracking, result build.
// Depends on cvfd_pkg.
`timescale 1ns / 1ps

module cvfd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,         // a stream byte is accepted this cycle
   input  logic [7:0]           stream_byte,
   output logic                 push,         // a result goes into the queue
   output cvfd_pkg::result_type result
);

   logic [3:0]  header_position_ff, header_position_in;
   logic [15:0] chunk_kind_ff, chunk_kind_in;
   logic [15:0] chunk_length_ff, chunk_length_in;
   logic        end_flag_seen_ff, end_flag_seen_in;
   logic [31:0] chunk_time_ff, chunk_time_in;
   logic [15:0] payload_left_ff, payload_left_in;
   logic        in_payload_ff, in_payload_in;
   logic        skipping_chunk_ff, skipping_chunk_in;
   logic        frame_open_ff, frame_open_in;
   logic [31:0] held_frame_time_ff, held_frame_time_in;
   logic        first_byte_pending_ff, first_byte_pending_in;
   logic [15:0] left_dec;
   logic        last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_position_ff    <= '0;
         chunk_kind_ff         <= '0;
         chunk_length_ff       <= '0;
         end_flag_seen_ff      <= 1'b0;
         chunk_time_ff         <= '0;
         payload_left_ff       <= '0;
         in_payload_ff         <= 1'b0;
         skipping_chunk_ff     <= 1'b0;
         frame_open_ff         <= 1'b0;
         held_frame_time_ff    <= '0;
         first_byte_pending_ff <= 1'b0;
      end else begin
         header_position_ff    <= header_position_in;
         chunk_kind_ff         <= chunk_kind_in;
         chunk_length_ff       <= chunk_length_in;
         end_flag_seen_ff      <= end_flag_seen_in;
         chunk_time_ff         <= chunk_time_in;
         payload_left_ff       <= payload_left_in;
         in_payload_ff         <= in_payload_in;
         skipping_chunk_ff     <= skipping_chunk_in;
         frame_open_ff         <= frame_open_in;
         held_frame_time_ff    <= held_frame_time_in;
         first_byte_pending_ff <= first_byte_pending_in;
      end
   end

   assign left_dec  = payload_left_ff - 16'd1;
   assign last_byte = (left_dec == 16'd0);

   always_comb begin
      header_position_in    = header_position_ff;
      chunk_kind_in         = chunk_kind_ff;
      chunk_length_in       = chunk_length_ff;
      end_flag_seen_in      = end_flag_seen_ff;
      chunk_time_in         = chunk_time_ff;
      payload_left_in       = payload_left_ff;
      in_payload_in         = in_payload_ff;
      skipping_chunk_in     = skipping_chunk_ff;
      frame_open_in         = frame_open_ff;
      held_frame_time_in    = held_frame_time_ff;
      first_byte_pending_in = first_byte_pending_ff;
      push                  = 1'b0;
      result                = '0;

      if (take) begin
         if (in_payload_ff) begin
            payload_left_in = left_dec;
            if (last_byte) begin
               in_payload_in = 1'b0;
            end
            if (!skipping_chunk_ff) begin
               push                   = 1'b1;
               result.payload_byte    = stream_byte;
               result.frame_time      = held_frame_time_ff;
               result.frame_start     = first_byte_pending_ff;
               result.frame_end       = last_byte && end_flag_seen_ff;
               first_byte_pending_in  = 1'b0;
               if (last_byte && end_flag_seen_ff) begin
                  frame_open_in = 1'b0;
               end
            end
         end else begin
            // shift header fields in, big-endian
            if (header_position_ff <= cvfd_pkg::PosKindLo) begin
               chunk_kind_in = {chunk_kind_ff[7:0], stream_byte};
            end
            if (header_position_ff == cvfd_pkg::PosLenHi ||
                header_position_ff == cvfd_pkg::PosLenLo) begin
               chunk_length_in = {chunk_length_ff[7:0], stream_byte};
            end
            if (header_position_ff == cvfd_pkg::PosFlagsLo) begin
               end_flag_seen_in = |(stream_byte & cvfd_pkg::EndFlagMask);
            end
            if (header_position_ff >= cvfd_pkg::PosTimeHi &&
                header_position_ff <= cvfd_pkg::PosTimeLo) begin
               chunk_time_in = {chunk_time_ff[23:0], stream_byte};
            end

            if (header_position_ff != cvfd_pkg::PosLast) begin
               header_position_in = header_position_ff + 4'd1;
            end else begin
               header_position_in = '0;
               if (chunk_length_ff <= cvfd_pkg::HdrOverhead) begin
                  // short chunk: report and drop the open frame
                  frame_open_in         = 1'b0;
                  first_byte_pending_in = 1'b0;
                  push                  = 1'b1;
                  result.bad_header     = 1'b1;
               end else begin
                  payload_left_in = chunk_length_ff - cvfd_pkg::HdrOverhead;
                  in_payload_in   = 1'b1;
                  if (chunk_kind_ff == cvfd_pkg::SkipKind) begin
                     skipping_chunk_in = 1'b1;
                  end else begin
                     skipping_chunk_in = 1'b0;
                     if (!frame_open_ff) begin
                        frame_open_in         = 1'b1;
                        held_frame_time_in    = chunk_time_ff;
                        first_byte_pending_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

endmodule

/* rtl/cvfd_queue.sv */
// Result queue between the deframer front end and the result port.
// Depends on cvfd_pkg.
`timescale 1ns / 1ps

module cvfd_queue #(
   parameter int unsigned DEPTH = cvfd_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cvfd_pkg::result_type push_data,
   output logic                 full,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output cvfd_pkg::result_type pop_data
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);

   cvfd_pkg::result_type entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CntW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrMax) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrMax) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/chunked_video_frame_deframer_top.sv */
// Top level of the chunked video frame deframer: front end plus result queue.
// Depends on cvfd_pkg, cvfd_front and cvfd_queue.
`timescale 1ns / 1ps

// Takes a chunked container stream one byte per item and returns the payload
// bytes of data chunks, each tagged with its frame's timestamp and with frame
// start and end marks. Each chunk opens with a 16-byte big-endian header (type,
// size, flags, chunk number, timestamp, fixed word); its payload is size minus
// 12 bytes. Type-258 chunks that carry a payload give no result. A chunk
// whose size leaves no payload gives one result with bad_header set and all
// else zero, and drops the open frame. The block takes one byte every cycle
// while the queue has room: the parser handles each byte as it is taken, and
// a small result queue (QUEUE_DEPTH items, four by default) lets the parser
// keep accepting while results wait on rsp_tready. req_tready falls only while
// that queue is full. A result shows on rsp_ once it is written into the queue.
module chunked_video_frame_deframer_top #(
   parameter int unsigned QUEUE_DEPTH = cvfd_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [7:0] payload_byte, [39:8] frame_time
   output logic        rsp_tlast,    // frame_end
   output logic [1:0]  rsp_tuser     // [0] frame_start, [1] bad_header
);

   logic                 take;
   logic                 push;
   logic                 full;
   cvfd_pkg::result_type front_result;
   cvfd_pkg::result_type out_result;

   // accept a byte whenever the queue has a free slot
   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;

   cvfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .stream_byte (req_tdata),
      .push        (push),
      .result      (front_result)
   );

   cvfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_result),
      .full      (full),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (out_result)
   );

   // pack the head-of-queue item onto the result port
   assign rsp_tdata = {out_result.frame_time, out_result.payload_byte};
   assign rsp_tlast = out_result.frame_end;
   assign rsp_tuser = {out_result.bad_header, out_result.frame_start};

endmodule

/* rtl/cvfd_checker.sv */
// Port-level checks for the chunked video frame deframer, bound to its top level.
// Depends on chunked_video_frame_deframer_top.
`timescale 1ns / 1ps

module cvfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // an error result carries nothing else
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 40'd0 && !rsp_tlast && !rsp_tuser[0])
      else $error("error result carries payload or marks");

   // reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // a result out of an empty queue needs a byte taken the cycle before
   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) && !$past(reset) |->
         $past(req_tvalid && req_tready))
      else $error("result without a byte taken");

endmodule

bind chunked_video_frame_deframer_top cvfd_checker u_cvfd_checker (.*);

/* bench/chunked_video_frame_deframer_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for chunked_video_frame_deframer_top: builds container byte streams,
// predicts every payload and bad-header result locally and checks rsp_ item by item.
// Depends on cvfd_pkg and the deframer RTL only.

module chunked_video_frame_deframer_top_tb;

   localparam int unsigned IdlePct     = 37;    // idle chance per cycle on either side
   localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
   localparam int unsigned StallLimit  = 4000;  // cycles without any handshake
   localparam int unsigned TailCycles  = 20;    // settle time after the last result
   localparam int unsigned RandomBytes = 220;
   localparam int unsigned CalmBytes   = 100;   // opening stretch with no idling
   localparam int unsigned MaxReports  = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;     // [7:0] stream_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [7:0] payload_byte, [39:8] frame_time
   logic        rsp_tlast;           // frame_end
   logic [1:0]  rsp_tuser;           // [0] frame_start, [1] bad_header

   chunked_video_frame_deframer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shared bench controls.
   logic        calm         = 1'b0;  // suppress idling on both sides
   int unsigned holds_asked  = 0;     // bump to start one receiver hold-off
   int unsigned holds_taken  = 0;
   int unsigned hold_left    = 0;
   int unsigned bytes_sent   = 0;
   int unsigned mismatches   = 0;
   int unsigned stall_cycles = 0;

   // Local copy of the deframer state: header parser, chunk body and frame tracking.
   logic [3:0]  hdr_pos      = '0;
   logic [15:0] hdr_kind     = '0;
   logic [15:0] hdr_size     = '0;
   logic        hdr_closes   = 1'b0;   // flag bit 0x80 seen in this header
   logic [31:0] hdr_stamp    = '0;
   logic [15:0] body_left    = '0;
   logic        in_body      = 1'b0;
   logic        body_dropped = 1'b0;   // body of a skipped chunk
   logic        frame_live   = 1'b0;
   logic [31:0] frame_stamp  = '0;
   logic        start_due    = 1'b0;   // next data byte opens a frame

   cvfd_pkg::result_type due_results[$];  // results still owed by the block, oldest first
   cvfd_pkg::result_type seen_result;
   cvfd_pkg::result_type owed_result;

   // Advance the local deframer by one stream byte; queue any result it owes.
   function automatic void deframe_byte(input logic [7:0] b);
      cvfd_pkg::result_type r;
      r = '0;
      if (in_body) begin
         body_left = body_left - 16'd1;
         if (body_left == 16'd0) begin
            in_body = 1'b0;
         end
         if (!body_dropped) begin
            r.payload_byte = b;
            r.frame_time   = frame_stamp;
            r.frame_start  = start_due;
            r.frame_end    = (body_left == 16'd0) && hdr_closes;
            start_due      = 1'b0;
            if (r.frame_end) begin
               frame_live = 1'b0;
            end
            due_results.push_back(r);
         end
      end else begin
         // Collect big-endian header fields; chunk number and fixed word are ignored.
         if (hdr_pos <= cvfd_pkg::PosKindLo) begin
            hdr_kind = {hdr_kind[7:0], b};
         end else if (hdr_pos <= cvfd_pkg::PosLenLo) begin
            hdr_size = {hdr_size[7:0], b};
         end else if (hdr_pos == cvfd_pkg::PosFlagsLo) begin
            hdr_closes = (b & cvfd_pkg::EndFlagMask) != 8'd0;
         end else if (hdr_pos >= cvfd_pkg::PosTimeHi && hdr_pos <= cvfd_pkg::PosTimeLo) begin
            hdr_stamp = {hdr_stamp[23:0], b};
         end
         if (hdr_pos != cvfd_pkg::PosLast) begin
            hdr_pos = hdr_pos + 4'd1;
         end else begin
            hdr_pos = '0;
            if (hdr_size <= cvfd_pkg::HdrOverhead) begin
               // Short chunk: report it and abandon the open frame.
               frame_live   = 1'b0;
               start_due    = 1'b0;
               r.bad_header = 1'b1;
               due_results.push_back(r);
            end else begin
               body_left    = hdr_size - cvfd_pkg::HdrOverhead;
               in_body      = 1'b1;
               body_dropped = (hdr_kind == cvfd_pkg::SkipKind);
               if (!body_dropped && !frame_live) begin
                  frame_live  = 1'b1;
                  frame_stamp = hdr_stamp;
                  start_due   = 1'b1;
               end
            end
         end
      end
   endfunction

   // Offer one stream byte, idling first at random; req_tvalid stays high on return.
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      deframe_byte(b);
   endtask

   // Send a 16-byte header with a random chunk number and fixed word.
   task automatic send_header(input logic [15:0] kind, input logic [15:0] size,
                              input logic [15:0] flags, input logic [31:0] stamp);
      logic [127:0] hdr;
      hdr = {kind, size, flags, 16'($urandom), stamp, $urandom};
      for (int i = 15; i >= 0; i--) begin
         send_byte(hdr[i*8 +: 8]);
      end
   endtask

   // Send a whole chunk with a random body of the length its size implies.
   task automatic send_chunk(input logic [15:0] kind, input logic [15:0] size,
                             input logic [15:0] flags, input logic [31:0] stamp);
      int unsigned body;
      send_header(kind, size, flags, stamp);
      body = (size > cvfd_pkg::HdrOverhead) ? int'(size - cvfd_pkg::HdrOverhead) : 0;
      repeat (body) send_byte(8'($urandom));
   endtask

   // Hold the sender until every owed result has come out.
   task automatic await_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   // One-byte and four-byte frames; payload and timestamp extremes.
   task automatic test_single_frame();
      send_header(16'h0001, cvfd_pkg::HdrOverhead + 16'd1, 16'h0080, 32'hFFFF_FFFF);
      send_byte(8'hFF);
      send_header(16'hFFFF, cvfd_pkg::HdrOverhead + 16'd4, 16'hFFFF, 32'h0000_0000);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(8'hA5);
   endtask

   // A frame over two chunks: the second chunk's timestamp must not replace the first.
   task automatic test_multi_chunk_frame();
      send_chunk(16'h0000, cvfd_pkg::HdrOverhead + 16'd2, 16'hFF7F, 32'h1234_5678);
      send_chunk(16'h0001, cvfd_pkg::HdrOverhead + 16'd1, 16'h0080, 32'hDEAD_BEEF);
   endtask

   // Skipped chunks give nothing and never close a frame, even with the end flag.
   task automatic test_skip_chunk();
      send_chunk(cvfd_pkg::SkipKind, cvfd_pkg::HdrOverhead + 16'd2, 16'hFFFF, 32'h0BAD_F00D);
      send_chunk(16'h0002, cvfd_pkg::HdrOverhead + 16'd2, 16'h0000, 32'h8000_0001);
      send_chunk(cvfd_pkg::SkipKind, cvfd_pkg::HdrOverhead + 16'd3, 16'hFFFF, 32'h7FFF_FFFE);
      send_chunk(16'h0003, cvfd_pkg::HdrOverhead + 16'd1, 16'h0080, 32'h0000_0002);
   endtask

   // Short chunks drop the open frame; the next header follows at once.
   task automatic test_short_chunk();
      send_chunk(16'h0004, cvfd_pkg::HdrOverhead + 16'd2, 16'h0000, 32'hCAFE_0001);
      send_chunk(16'h0005, cvfd_pkg::HdrOverhead, 16'h0080, 32'hCAFE_0002);
      send_chunk(16'h0006, cvfd_pkg::HdrOverhead + 16'd1, 16'h0080, 32'hCAFE_0003);
      send_chunk(cvfd_pkg::SkipKind, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
      send_chunk(16'h0007, 16'h0001, 16'h0000, 32'h0000_0000);
      await_results();
   endtask

   // Stop taking results for a long stretch while a long body keeps arriving.
   task automatic test_receiver_holdoff();
      holds_asked++;
      send_chunk(16'h0008, cvfd_pkg::HdrOverhead + 16'd64, 16'h0080, $urandom);
      await_results();
   endtask

   // Mostly well-formed chunks with random content, mixed with short and skipped ones.
   task automatic test_random_stream();
      int unsigned base;
      int unsigned pick;
      logic [15:0] kind;
      logic [15:0] size;
      base = bytes_sent;
      while (bytes_sent - base < RandomBytes) begin
         calm = (bytes_sent - base) < CalmBytes;
         pick = $urandom_range(99);
         kind = (pick >= 20 && pick < 40) ? cvfd_pkg::SkipKind : 16'($urandom);
         if (pick < 10) begin
            size = 16'($urandom_range(cvfd_pkg::HdrOverhead));
         end else if (pick < 13) begin
            size = 16'h0100 | 16'($urandom_range(255));
         end else begin
            size = cvfd_pkg::HdrOverhead + 16'd1 + 16'($urandom_range(23));
         end
         send_chunk(kind, size, 16'($urandom), $urandom);
      end
      calm = 1'b0;
   endtask

   // A chunk longer than 255 bytes: the body counter carries into its high byte.
   task automatic test_max_chunk();
      send_chunk(16'h7FFF, 16'h0110, 16'h0080, 32'hA5A5_5A5A);
   endtask

   // Receiver: idle at random, or hold off for HoldCycles when a test asks.
   always @(posedge clock) begin : drive_rsp_ready
      if (holds_taken != holds_asked) begin
         holds_taken = holds_asked;
         hold_left   = HoldCycles;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= IdlePct);
      end
   end

   // Compare each accepted result with the oldest owed one.
   always @(posedge clock) begin : check_results
      if (rsp_tvalid && rsp_tready) begin
         seen_result.payload_byte = rsp_tdata[7:0];
         seen_result.frame_time   = rsp_tdata[39:8];
         seen_result.frame_start  = rsp_tuser[0];
         seen_result.bad_header   = rsp_tuser[1];
         seen_result.frame_end    = rsp_tlast;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
               $display("%0t: unexpected result %h (bad,end,start,time,byte)",
                        $time, seen_result);
            end
         end else begin
            owed_result = due_results.pop_front();
            if (seen_result !== owed_result) begin
               mismatches++;
               if (mismatches <= MaxReports) begin
                  $display("%0t: expected %h actual %h (bad,end,start,time,byte)",
                           $time, owed_result, seen_result);
               end
            end
         end
      end
   end

   // End the run if no item moves on either side for too long.
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_single_frame();
      test_multi_chunk_frame();
      test_skip_chunk();
      test_short_chunk();
      test_receiver_holdoff();
      test_random_stream();
      test_max_chunk();
      await_results();
      // Give any stray result time to show up before the verdict.
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
